@@ src/vrdq_pkg.sv @@
package vrdq_pkg;

  localparam int NUM_CHAN     = 8;
  localparam int MAX_CHANNELS = 8;

  localparam int CHAN_W     = 20;
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 17;
  localparam int PCT_W      = 7;
  localparam int CNT_W      = 4;
  localparam int DIV_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // seven summed channels of 20 bits
  localparam int SUM_W  = 23;
  localparam int PROD_W = SUM_W + GAIN_W + 1;
  // |sum| * gain stays below 2^38
  localparam int MAG_W  = 38;
  localparam int FRAC_SHIFT  = 32;
  localparam int FULL_SHIFT  = 15;
  localparam int SCALED_W    = MAG_W + FULL_SHIFT;
  localparam int T_W         = 18;
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 20;
  localparam int RAW_SHIFT   = 16;

  localparam int LANE_DEPTH  = 4;

  localparam int IN_DATA_W   = NUM_CHAN * CHAN_W;
  localparam int OUT_FIELD_W = 2 * SAMPLE_W + GAIN_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(65536);
  localparam int RAMP_STEP   = 16384;
  localparam logic signed [GAIN_W:0] RAMP_STEP_S = (GAIN_W+1)'(RAMP_STEP);
  localparam int PERCENT_MAX = 100;
  localparam logic [SAMPLE_W-1:0] S16_FULL = SAMPLE_W'(32767);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOLUME   = 2'd0,
    REG_CHANNELS = 2'd1,
    REG_RAW      = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_ZERO = 2'd0,
    MODE_RAW  = 2'd1,
    MODE_DEC  = 2'd2
  } lane_mode_t;

  typedef struct packed {
    logic [CNT_W-1:0] channel_count;
    logic             raw_mode;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    lane_mode_t        mode;
    logic [SUM_W-1:0]  sum;
    logic [GAIN_W-1:0] gain;
    logic [DIV_W-1:0]  div;
  } lane_in_t;

  typedef struct packed {
    logic                valid;
    lane_mode_t          mode;
    logic                neg;
    logic                clamp;
    logic [SAMPLE_W-1:0] qraw;
    logic [SAMPLE_W-1:0] qdec;
  } lane_out_t;

  typedef logic [(1 << PCT_W)-1:0][GAIN_W-1:0] gain_lut_t;

  // target gain (p/100)^2 in q1.16, rounded to nearest
  function automatic gain_lut_t build_gain_lut();
    gain_lut_t lut;
    for (int p = 0; p < (1 << PCT_W); p++) begin
      if (p >= PERCENT_MAX) begin
        lut[p] = UNITY_GAIN;
      end else begin
        lut[p] = GAIN_W'((p * p * 65536 + 5000) / 10000);
      end
    end
    return lut;
  endfunction

  localparam gain_lut_t GAIN_LUT = build_gain_lut();

  // floor(2^20 / d) for the downmix divisors
  function automatic logic [RECIP_W-1:0] recip_of(input logic [DIV_W-1:0] d);
    logic [RECIP_W-1:0] r;
    unique case (d)
      4'd3:    r = RECIP_W'(349525);
      4'd4:    r = RECIP_W'(262144);
      4'd5:    r = RECIP_W'(209715);
      4'd6:    r = RECIP_W'(174762);
      4'd7:    r = RECIP_W'(149796);
      4'd8:    r = RECIP_W'(131072);
      default: r = RECIP_W'(1048576);
    endcase
    return r;
  endfunction

endpackage

@@ src/vrdq_gain.sv @@
module vrdq_gain
  import vrdq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  step,
  output cfg_t                  cfg,
  output logic [GAIN_W-1:0]     gain_cur,
  output logic [GAIN_W-1:0]     gain_next
);

  logic [PCT_W-1:0]  vol_pct;
  logic [CNT_W-1:0]  channel_count;
  logic              raw_mode;
  logic [GAIN_W-1:0] cur_gain;

  logic [PCT_W-1:0]       pct_in;
  logic [GAIN_W-1:0]      target;
  logic signed [GAIN_W:0] delta;

  assign pct_in = cfg_data[PCT_W-1:0];
  assign target = GAIN_LUT[vol_pct];
  assign delta  = $signed({1'b0, target}) - $signed({1'b0, cur_gain});

  always_comb begin
    if (delta > RAMP_STEP_S) begin
      gain_next = cur_gain + GAIN_W'(RAMP_STEP);
    end else if (delta < -RAMP_STEP_S) begin
      gain_next = cur_gain - GAIN_W'(RAMP_STEP);
    end else begin
      gain_next = target;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vol_pct       <= PCT_W'(PERCENT_MAX);
      channel_count <= CNT_W'(2);
      raw_mode      <= 1'b0;
      cur_gain      <= UNITY_GAIN;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_VOLUME: begin
            vol_pct <= (pct_in > PCT_W'(PERCENT_MAX)) ? PCT_W'(PERCENT_MAX) : pct_in;
          end
          REG_CHANNELS: begin
            channel_count <= cfg_data[CNT_W-1:0];
          end
          REG_RAW: begin
            raw_mode <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
      if (step) begin
        cur_gain <= gain_next;
      end
    end
  end

  assign cfg.channel_count = channel_count;
  assign cfg.raw_mode      = raw_mode;
  assign gain_cur          = cur_gain;

  a_gain_bounded: assert property (@(posedge clk) disable iff (rst)
    cur_gain <= UNITY_GAIN)
    else $error("applied gain above unity");

  a_gain_holds: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(cur_gain))
    else $error("gain moved without a block start");

  a_gain_step_size: assert property (@(posedge clk) disable iff (rst)
    step |=> (((cur_gain >= $past(cur_gain)) ?
               (cur_gain - $past(cur_gain)) :
               ($past(cur_gain) - cur_gain)) <= GAIN_W'(RAMP_STEP)))
    else $error("gain ramp step too large");

endmodule

@@ src/vrdq_lane.sv @@
module vrdq_lane
  import vrdq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      adv,
  input  lane_in_t  lin,
  output lane_out_t lout
);

  // multiply by gain
  logic                     v1;
  lane_mode_t               mode1;
  logic [DIV_W-1:0]         div1;
  logic signed [PROD_W-1:0] prod1;

  // magnitude
  logic             v2;
  lane_mode_t       mode2;
  logic [DIV_W-1:0] div2;
  logic             neg2;
  logic [MAG_W-1:0] mag2;

  // scale to full range, clamp test
  logic                v3;
  lane_mode_t          mode3;
  logic [DIV_W-1:0]    div3;
  logic                neg3;
  logic                clamp3;
  logic [T_W-1:0]      t3;
  logic [SAMPLE_W-1:0] qraw3;

  // reciprocal estimate of the quotient
  logic                v4;
  lane_mode_t          mode4;
  logic [DIV_W-1:0]    div4;
  logic                neg4;
  logic                clamp4;
  logic [T_W-1:0]      t4;
  logic [SAMPLE_W-1:0] qraw4;
  logic [SAMPLE_W-1:0] q0;

  logic signed [PROD_W-1:0]   prod_c;
  logic [PROD_W-1:0]          abs_c;
  logic [SCALED_W-1:0]        scaled_c;
  logic [T_W+RECIP_W-1:0]     est_c;
  logic [SAMPLE_W+DIV_W-1:0]  qd_c;
  logic [T_W-1:0]             rem_c;

  assign prod_c   = $signed(lin.sum) * $signed({1'b0, lin.gain});
  assign abs_c    = prod1[PROD_W-1] ? PROD_W'(-prod1) : PROD_W'(prod1);
  assign scaled_c = {mag2, FULL_SHIFT'(0)} - SCALED_W'(mag2);
  assign est_c    = t3 * recip_of(div3);
  assign qd_c     = q0 * div4;
  assign rem_c    = t4 - qd_c[T_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= lin.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode1  <= lin.mode;
      div1   <= lin.div;
      prod1  <= prod_c;

      mode2  <= mode1;
      div2   <= div1;
      neg2   <= prod1[PROD_W-1];
      mag2   <= abs_c[MAG_W-1:0];

      mode3  <= mode2;
      div3   <= div2;
      neg3   <= neg2;
      clamp3 <= mag2[MAG_W-1:FRAC_SHIFT] >= (MAG_W-FRAC_SHIFT)'(div2);
      t3     <= scaled_c[FRAC_SHIFT +: T_W];
      qraw3  <= mag2[RAW_SHIFT +: SAMPLE_W];

      mode4  <= mode3;
      div4   <= div3;
      neg4   <= neg3;
      clamp4 <= clamp3;
      t4     <= t3;
      qraw4  <= qraw3;
      q0     <= est_c[RECIP_SHIFT +: SAMPLE_W];
    end
  end

  assign lout.valid = v4;
  assign lout.mode  = mode4;
  assign lout.neg   = neg4;
  assign lout.clamp = clamp4;
  assign lout.qraw  = qraw4;
  assign lout.qdec  = (rem_c >= T_W'(div4)) ? q0 + SAMPLE_W'(1) : q0;

endmodule

@@ src/vrdq_merge.sv @@
module vrdq_merge
  import vrdq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  lane_out_t             left_res,
  input  lane_out_t             right_res,
  input  logic [GAIN_W-1:0]     gain,
  output logic                  m_tvalid,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  function automatic logic [SAMPLE_W-1:0] finish(input lane_out_t r);
    logic [SAMPLE_W-1:0] mag;
    logic [SAMPLE_W-1:0] res;
    mag = r.clamp ? S16_FULL : r.qdec;
    unique case (r.mode)
      MODE_DEC: res = r.neg ? SAMPLE_W'(-mag) : mag;
      MODE_RAW: res = r.neg ? SAMPLE_W'(-r.qraw) : r.qraw;
      default:  res = '0;
    endcase
    return res;
  endfunction

  logic [SAMPLE_W-1:0] left_s;
  logic [SAMPLE_W-1:0] right_s;

  assign left_s  = finish(left_res);
  assign right_s = finish(right_res);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= left_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {(OUT_DATA_W-OUT_FIELD_W)'(0), gain, right_s, left_s};
    end
  end

endmodule

@@ src/volume_ramp_downmix_quantizer.sv @@
// Stereo output stage with a master-volume gain ramp. Each input item is a
// block start (tuser low), which moves the applied gain one step of at most
// 0.25 toward (volume/100)^2, or an audio frame (tuser high) that is
// mapped to stereo by channel count, scaled by the gain, clamped and truncated
// to s16; raw mode scales two s16 samples only. Every item gives one result
// carrying both samples and the gain in effect after the item. The block is a
// six-stage pipeline (input register, four stages in each of the left and right
// lanes, output register); one item per cycle is taken as long as results are
// drained.
// When a result waits at the output the whole pipeline holds and tready drops.
// Configuration writes take effect at the next edge; write only while idle.
module volume_ramp_downmix_quantizer
  import vrdq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // chan0 .. chan7, 20 bits each
  input  logic                  s_tuser,   // req_type
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // left_out, right_out, gain_in_effect
);

  logic adv;
  logic accept;
  logic step;

  cfg_t              cfg;
  logic [GAIN_W-1:0] gain_cur;
  logic [GAIN_W-1:0] gain_next;
  logic [GAIN_W-1:0] gain_item;

  logic signed [CHAN_W-1:0] chan [NUM_CHAN];
  logic [CNT_W-1:0]         n_eff;
  logic signed [SUM_W-1:0]  extra;
  logic signed [SUM_W-1:0]  sum_l;
  logic signed [SUM_W-1:0]  sum_r;
  logic [DIV_W-1:0]         div_c;
  lane_mode_t               mode_c;

  lane_in_t  left_in;
  lane_in_t  right_in;
  lane_out_t left_res;
  lane_out_t right_res;

  logic [GAIN_W-1:0] gain_line [LANE_DEPTH];

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign accept   = s_tvalid && adv;
  assign step     = accept && !s_tuser;

  vrdq_gain u_gain (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .cfg       (cfg),
    .gain_cur  (gain_cur),
    .gain_next (gain_next)
  );

  assign gain_item = s_tuser ? gain_cur : gain_next;

  for (genvar k = 0; k < NUM_CHAN; k++) begin : g_chan
    assign chan[k] = s_tdata[k*CHAN_W +: CHAN_W];
  end

  assign n_eff = (cfg.channel_count == '0) ? CNT_W'(2) : cfg.channel_count;

  always_comb begin
    extra = '0;
    for (int k = 2; k < NUM_CHAN; k++) begin
      if (CNT_W'(k) < n_eff) begin
        extra = extra + SUM_W'(chan[k]);
      end
    end
  end

  always_comb begin
    div_c = (n_eff > CNT_W'(2)) ? DIV_W'(n_eff) : DIV_W'(1);
    if (cfg.raw_mode) begin
      sum_l = SUM_W'($signed(chan[0][SAMPLE_W-1:0]));
      sum_r = SUM_W'($signed(chan[1][SAMPLE_W-1:0]));
    end else begin
      sum_l = SUM_W'(chan[0]) + extra;
      sum_r = (n_eff == CNT_W'(1)) ? SUM_W'(chan[0]) : SUM_W'(chan[1]) + extra;
    end
    if (!s_tuser) begin
      mode_c = MODE_ZERO;
    end else if (cfg.raw_mode) begin
      mode_c = MODE_RAW;
    end else if (n_eff > CNT_W'(MAX_CHANNELS)) begin
      mode_c = MODE_ZERO;
    end else begin
      mode_c = MODE_DEC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_in.valid  <= 1'b0;
      right_in.valid <= 1'b0;
    end else if (adv) begin
      left_in.valid  <= s_tvalid;
      right_in.valid <= s_tvalid;
    end
    if (adv) begin
      left_in.mode   <= mode_c;
      left_in.sum    <= sum_l;
      left_in.gain   <= gain_item;
      left_in.div    <= div_c;
      right_in.mode  <= mode_c;
      right_in.sum   <= sum_r;
      right_in.gain  <= gain_item;
      right_in.div   <= div_c;
      gain_line[0]   <= left_in.gain;
      for (int k = 1; k < LANE_DEPTH; k++) begin
        gain_line[k] <= gain_line[k-1];
      end
    end
  end

  vrdq_lane u_lane_left (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .lin  (left_in),
    .lout (left_res)
  );

  vrdq_lane u_lane_right (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .lin  (right_in),
    .lout (right_res)
  );

  vrdq_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .left_res  (left_res),
    .right_res (right_res),
    .gain      (gain_line[LANE_DEPTH-1]),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata)
  );

endmodule

@@ test/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vrdq_pkg::*;

  typedef struct packed {
    logic [GAIN_W-1:0]   gain;
    logic [SAMPLE_W-1:0] right_s;
    logic [SAMPLE_W-1:0] left_s;
  } stereo_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  // shadow of the block's settings and gain ramp
  int     vol_pct = PERCENT_MAX;
  int     chan_setting = 2;
  bit     raw_path = 1'b0;
  longint gain_now = 65536;

  stereo_t stereo_expected[$];
  int      errors = 0;
  int      sender_idle_pct = 0;
  int      stall_pct = 0;
  int      hold_left = 0;

  volume_ramp_downmix_quantizer DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("[volume_ramp_downmix_quantizer] ERROR");
    $finish;
  end

  function automatic longint chan_q(input logic [IN_DATA_W-1:0] data, input int i);
    return longint'($signed(data[i*CHAN_W +: CHAN_W]));
  endfunction

  function automatic longint chan_s16(input logic [IN_DATA_W-1:0] data, input int i);
    return longint'($signed(data[i*CHAN_W +: SAMPLE_W]));
  endfunction

  // sum * gain / (div * 2^32), clamped to full scale, times 32767, toward zero
  function automatic longint clamp_to_s16(input longint sum, input longint div);
    longint prod, mag, lim, q;
    prod = sum * gain_now;
    mag = (prod < 0) ? -prod : prod;
    lim = div << 32;
    q = (mag >= lim) ? 32767 : (mag * 32767) / lim;
    return (prod < 0) ? -q : q;
  endfunction

  function automatic longint raw_to_s16(input longint v);
    longint prod, mag;
    prod = v * gain_now;
    mag = (prod < 0) ? -prod : prod;
    return (prod < 0) ? -(mag >> 16) : (mag >> 16);
  endfunction

  function automatic stereo_t downmix_frame(input logic req, input logic [IN_DATA_W-1:0] data);
    stereo_t res;
    longint tgt, delta, l, r, extra, n, div;
    l = 0;
    r = 0;
    if (!req) begin
      tgt = (vol_pct >= PERCENT_MAX) ? 65536
          : (longint'(vol_pct) * vol_pct * 65536 + 5000) / 10000;
      delta = tgt - gain_now;
      if (delta > RAMP_STEP) begin
        gain_now += RAMP_STEP;
      end else if (delta < -RAMP_STEP) begin
        gain_now -= RAMP_STEP;
      end else begin
        gain_now = tgt;
      end
    end else if (raw_path) begin
      l = raw_to_s16(chan_s16(data, 0));
      r = raw_to_s16(chan_s16(data, 1));
    end else begin
      n = (chan_setting == 0) ? 2 : chan_setting;
      if (n <= MAX_CHANNELS) begin
        l = chan_q(data, 0);
        r = (n == 1) ? l : chan_q(data, 1);
        extra = 0;
        for (int i = 2; i < n; i++) begin
          extra += chan_q(data, i);
        end
        div = (n > 2) ? n : 1;
        l = clamp_to_s16(l + extra, div);
        r = clamp_to_s16(r + extra, div);
      end
    end
    res.left_s = l[SAMPLE_W-1:0];
    res.right_s = r[SAMPLE_W-1:0];
    res.gain = gain_now[GAIN_W-1:0];
    return res;
  endfunction

  function automatic logic [IN_DATA_W-1:0] make_frame(input int c0, input int c1, input int rest);
    logic [IN_DATA_W-1:0] d;
    d[0 +: CHAN_W] = CHAN_W'(c0);
    d[CHAN_W +: CHAN_W] = CHAN_W'(c1);
    for (int i = 2; i < NUM_CHAN; i++) begin
      d[i*CHAN_W +: CHAN_W] = CHAN_W'(rest);
    end
    return d;
  endfunction

  function automatic logic [CHAN_W-1:0] random_sample();
    logic [CHAN_W-1:0] s;
    case ($urandom_range(3))
      0: s = CHAN_W'($urandom);
      1: s = CHAN_W'(int'($urandom_range(196607)) - 98304);
      2: s = CHAN_W'(($urandom_range(1) ? 65536 : -65536) + int'($urandom_range(64)) - 32);
      default: begin
        case ($urandom_range(3))
          0: s = CHAN_W'(524287);
          1: s = CHAN_W'(-524288);
          2: s = '0;
          default: s = CHAN_W'(-1);
        endcase
      end
    endcase
    return s;
  endfunction

  function automatic logic [IN_DATA_W-1:0] random_frame();
    logic [IN_DATA_W-1:0] d;
    for (int i = 0; i < NUM_CHAN; i++) begin
      d[i*CHAN_W +: CHAN_W] = random_sample();
    end
    return d;
  endfunction

  always @(posedge clk) begin
    stereo_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[OUT_FIELD_W-1:0];
      if (stereo_expected.size() == 0) begin
        $error("result with no item pending: %h", got);
        errors++;
      end else begin
        want = stereo_expected.pop_front();
        if (got.left_s !== want.left_s) begin
          $error("left_out: expected %0d, got %0d", $signed(want.left_s), $signed(got.left_s));
          errors++;
        end
        if (got.right_s !== want.right_s) begin
          $error("right_out: expected %0d, got %0d", $signed(want.right_s),
                 $signed(got.right_s));
          errors++;
        end
        if (got.gain !== want.gain) begin
          $error("gain_in_effect: expected %0d, got %0d", want.gain, got.gain);
          errors++;
        end
      end
    end
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_item(input logic req, input logic [IN_DATA_W-1:0] data);
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= data;
    do @(posedge clk); while (!s_tready);
    stereo_expected.push_back(downmix_frame(req, data));
  endtask

  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    while (stereo_expected.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic apply_settings(input int pct, input int cnt, input int raw);
    wait_all_results();
    cfg_we <= 1'b1;
    cfg_index <= REG_VOLUME;
    cfg_data <= CFG_DATA_W'(pct);
    @(posedge clk);
    cfg_index <= REG_CHANNELS;
    cfg_data <= CFG_DATA_W'(cnt);
    @(posedge clk);
    cfg_index <= REG_RAW;
    cfg_data <= CFG_DATA_W'(raw);
    @(posedge clk);
    cfg_we <= 1'b0;
    vol_pct = ((pct & 127) > PERCENT_MAX) ? PERCENT_MAX : (pct & 127);
    chan_setting = cnt & 15;
    raw_path = raw & 1;
  endtask

  task automatic test_directed();
    sender_idle_pct = 0;
    stall_pct = 0;
    // reset settings: unity gain, stereo pass-through
    send_item(1'b1, make_frame(524287, 524287, 0));
    send_item(1'b1, make_frame(-524288, -524288, 0));
    send_item(1'b1, make_frame(65536, -65536, 0));
    send_item(1'b1, make_frame(65535, -1, 0));
    send_item(1'b0, '0);
    // volume above the top clamps, full eight-channel downmix
    apply_settings(127, 8, 0);
    send_item(1'b1, make_frame(524287, 524287, 524287));
    send_item(1'b1, make_frame(524287, -524288, 30000));
    send_item(1'b0, '0);
    // ramp down to silence, mono duplicate
    apply_settings(0, 1, 0);
    send_item(1'b0, '0);
    send_item(1'b1, make_frame(100000, 7, 7));
    send_item(1'b0, '0);
    send_item(1'b0, '0);
    send_item(1'b0, '0);
    send_item(1'b1, make_frame(-524288, 5, 5));
    // raw path ignores count and upper bits
    apply_settings(50, 9, 1);
    send_item(1'b0, '0);
    send_item(1'b1, make_frame(32768, -32769, 12345));
    // count above the maximum gives silence, ramp back up
    apply_settings(100, 9, 0);
    send_item(1'b1, make_frame(1000, 2000, 3000));
    send_item(1'b0, '0);
    send_item(1'b0, '0);
    send_item(1'b0, '0);
    apply_settings(100, 0, 1);
    send_item(1'b1, make_frame(32768, 32767, 0));
    apply_settings(100, 15, 0);
    send_item(1'b1, make_frame(524287, 524287, 524287));
    apply_settings(100, 0, 0);
    send_item(1'b1, make_frame(40000, -40000, 524287));
  endtask

  task automatic test_random_settings();
    int pct, cnt, raw;
    for (int phase = 0; phase < 16; phase++) begin
      case ($urandom_range(4))
        0: pct = 0;
        1: pct = 100;
        2: pct = $urandom_range(127, 101);
        default: pct = $urandom_range(99);
      endcase
      cnt = ($urandom_range(9) == 0) ? $urandom_range(15, 9) : $urandom_range(8);
      raw = ($urandom_range(3) == 0);
      apply_settings(pct, cnt, raw);
      case (phase % 4)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 76; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 76; end
        default: begin sender_idle_pct = 15; stall_pct = 15; end
      endcase
      for (int k = 0; k < 30; k++) begin
        if ($urandom_range(3) == 0) begin
          send_item(1'b0, random_frame());
        end else begin
          send_item(1'b1, random_frame());
        end
      end
    end
  endtask

  task automatic test_backpressure();
    apply_settings($urandom_range(100), $urandom_range(8), 0);
    sender_idle_pct = 0;
    stall_pct = 0;
    hold_left = 80;
    for (int k = 0; k < 24; k++) begin
      send_item(k % 5 == 0 ? 1'b0 : 1'b1, random_frame());
    end
  endtask

  task automatic test_sender_pause();
    sender_idle_pct = 15;
    stall_pct = 15;
    for (int k = 0; k < 8; k++) begin
      send_item(k % 3 == 0 ? 1'b0 : 1'b1, random_frame());
    end
    wait_all_results();
    for (int k = 0; k < 8; k++) begin
      send_item(k % 3 == 0 ? 1'b0 : 1'b1, random_frame());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_settings();
    test_backpressure();
    test_sender_pause();
    wait_all_results();
    if (errors == 0) begin
      $display("[volume_ramp_downmix_quantizer] OK");
    end else begin
      $display("[volume_ramp_downmix_quantizer] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/vrdq_pkg.sv
src/vrdq_gain.sv
src/vrdq_lane.sv
src/vrdq_merge.sv
src/volume_ramp_downmix_quantizer.sv
test/tb.sv
